### rtl/nxc_pkg.sv
// Shared types and constants of the next-combination unit.
package nxc_pkg;

   // Register indexes of the configuration port.
   localparam int unsigned CSR_INDEX_BITS = 1;
   localparam int unsigned CSR_DATA_BITS  = 8;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SET_SIZE    = 1'b0,
      CSR_CHOOSE_SIZE = 1'b1
   } csr_index_type;

   // Field widths of the configuration registers.
   localparam int unsigned SET_SIZE_BITS    = 8;
   localparam int unsigned CHOOSE_SIZE_BITS = 5;

   // Reset values of the configuration registers.
   localparam logic [SET_SIZE_BITS-1:0]    SET_SIZE_RESET    = 8'd8;
   localparam logic [CHOOSE_SIZE_BITS-1:0] CHOOSE_SIZE_RESET = 5'd3;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_EMIT,
      ST_NONE
   } state_type;

endpackage

### rtl/nxc_req_if.sv
// Input channel of the next-combination unit: one element per transfer.
interface nxc_req_if #(
   parameter int unsigned VALUE_BITS = 8
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] element;

   modport source (output valid, output element, input ready);
   modport sink   (input valid, input element, output ready);
endinterface

### rtl/nxc_rsp_if.sv
// Result channel of the next-combination unit: one element of the next combination per transfer.
interface nxc_rsp_if #(
   parameter int unsigned VALUE_BITS = 8
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] element_res;
   logic                  last;
   logic                  no_next;

   modport source (output valid, output element_res, output last, output no_next, input ready);
   modport sink   (input valid, input element_res, input last, input no_next, output ready);
endinterface

### rtl/nxc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module nxc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/next_combination_unit.sv
// Next k-combination unit: takes a combination element by element, returns the next one.
// The k-th element transfer moves the sequencer into its result phase, which loads the
// result register once that is free. Results are returned one per cycle while the receiver
// takes them, out of the element RAM's single read port; no element is taken in the
// result phase. A combination without a successor returns a single no-next result.
// Reset: sequencer, load count and result valid flag are cleared, set_size is 8 and
// choose_size is 3; the element RAM is not cleared, since every run writes it first.
module next_combination_unit #(
   parameter int unsigned MAX_K      = 16,
   parameter int unsigned VALUE_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   nxc_req_if.sink                              req_chan,
   nxc_rsp_if.source                            rsp_chan,
   input  logic                                 csr_wr_en,
   input  logic [nxc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [nxc_pkg::CSR_DATA_BITS-1:0]    csr_wr_data
);
   import nxc_pkg::*;

   localparam int unsigned IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_K + 1);
   // Width for the position test a + k <= n + pos.
   localparam int unsigned SUM_W = ((VALUE_BITS > 9) ? VALUE_BITS : 9) + 1;

   // Configuration registers.
   logic [SET_SIZE_BITS-1:0]    set_size_ff;
   logic [CHOOSE_SIZE_BITS-1:0] choose_size_ff;

   // Sequencer and run state.
   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      grow_ff, grow_in;
   logic [VALUE_BITS-1:0] fill_ff, fill_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_elem_ff, rsp_elem_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_none_ff, rsp_none_in;

   logic [CNT_W-1:0]      eff_k;
   logic                  req_xfer;
   logic                  slot_free;
   logic                  last_load;
   logic                  last_emit;
   logic                  can_grow;
   logic [SUM_W-1:0]      sum_elem;
   logic [SUM_W-1:0]      sum_limit;
   logic [VALUE_BITS-1:0] rd_data;

   // Effective k: zero acts as one, anything above MAX_K acts as MAX_K.
   always_comb begin
      if (choose_size_ff == '0) begin
         eff_k = CNT_W'(1);
      end else if (32'(choose_size_ff) > MAX_K) begin
         eff_k = CNT_W'(MAX_K);
      end else begin
         eff_k = CNT_W'(choose_size_ff);
      end
   end

   assign req_chan.ready = (state_ff == ST_LOAD);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign last_load      = (CNT_W'(cnt_ff) + CNT_W'(1)) == eff_k;
   assign last_emit      = (CNT_W'(pos_ff) + CNT_W'(1)) == eff_k;

   // Position test a[pos] < n - k + pos + 1, rearranged to stay unsigned.
   assign sum_elem  = SUM_W'(req_chan.element) + SUM_W'(eff_k);
   assign sum_limit = SUM_W'(set_size_ff) + SUM_W'(cnt_ff);
   assign can_grow  = sum_elem <= sum_limit;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         set_size_ff    <= SET_SIZE_RESET;
         choose_size_ff <= CHOOSE_SIZE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SET_SIZE: begin
               set_size_ff <= csr_wr_data[SET_SIZE_BITS-1:0];
            end
            CSR_CHOOSE_SIZE: begin
               choose_size_ff <= csr_wr_data[CHOOSE_SIZE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Element store; the read address follows the next emit position so that
   // the read data matches the current position.
   nxc_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_K)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (req_xfer),
      .wr_addr (cnt_ff),
      .wr_data (req_chan.element),
      .rd_addr (pos_in),
      .rd_data (rd_data)
   );

   // Next state, run tracking and result register loading.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      grow_in      = grow_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_elem_in  = rsp_elem_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_none_in  = rsp_none_ff;

      unique case (state_ff)
         ST_LOAD: begin
            pos_in = '0;
            if (req_xfer) begin
               // The rightmost passing position wins, so later ones overwrite.
               if (can_grow) begin
                  found_in = 1'b1;
                  grow_in  = cnt_ff;
                  fill_in  = req_chan.element + VALUE_BITS'(1);
               end
               if (last_load) begin
                  cnt_in   = '0;
                  found_in = 1'b0;
                  state_in = (can_grow || found_ff) ? ST_EMIT : ST_NONE;
               end else begin
                  cnt_in = cnt_ff + IDX_W'(1);
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = last_emit;
               rsp_none_in  = 1'b0;
               // Positions left of the grow point keep their stored value.
               if (pos_ff < grow_ff) begin
                  rsp_elem_in = rd_data;
               end else begin
                  rsp_elem_in = fill_ff;
                  fill_in     = fill_ff + VALUE_BITS'(1);
               end
               if (last_emit) begin
                  pos_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  pos_in = pos_ff + IDX_W'(1);
               end
            end
         end
         ST_NONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_elem_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_none_in  = 1'b1;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      // A configuration write drops a partly loaded combination.
      if (csr_wr_en) begin
         cnt_in   = '0;
         found_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      grow_ff     <= grow_in;
      fill_ff     <= fill_in;
      rsp_elem_ff <= rsp_elem_in;
      rsp_last_ff <= rsp_last_in;
      rsp_none_ff <= rsp_none_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.element_res = rsp_elem_ff;
   assign rsp_chan.last        = rsp_last_ff;
   assign rsp_chan.no_next     = rsp_none_ff;

   // The transfer that completes a combination always starts a result phase.
   a_complete_starts_output: assert property (@(posedge clock) disable iff (reset)
      req_xfer && last_load |=> state_ff != ST_LOAD)
      else $error("completed combination did not start a result phase");

   // A no-next result is a single, final result with a zero element.
   a_no_next_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_none_ff |-> rsp_last_ff && (rsp_elem_ff == '0))
      else $error("malformed no-next result");

   // The emit position never runs past the effective k.
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> CNT_W'(pos_ff) < eff_k)
      else $error("emit position beyond k");

   // While loading, the element count stays below the effective k.
   a_cnt_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> CNT_W'(cnt_ff) < eff_k)
      else $error("load count beyond k");

endmodule

### tb/testbench.sv
// Testbench of the next-combination unit: directed and random combinations checked against a predictor.
`timescale 1ns / 1ps
module testbench;
   import nxc_pkg::*;

   localparam int unsigned MAX_K         = 16;
   localparam int unsigned VALUE_BITS    = 8;
   localparam int unsigned MAX_WAIT      = 13;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned RANDOM_ITEMS  = 340;
   localparam int unsigned REPORT_LIMIT  = 10;
   localparam int unsigned EXTREME_COUNT = 10;

   // One element of the successor combination, as the result channel carries it.
   typedef struct packed {
      logic [VALUE_BITS-1:0] element_res;
      logic                  last;
      logic                  no_next;
   } successor_type;

   logic                        clock       = 1'b0;
   logic                        reset       = 1'b1;
   logic                        csr_wr_en   = 1'b0;
   logic [CSR_INDEX_BITS-1:0]   csr_index   = CSR_SET_SIZE;
   logic [CSR_DATA_BITS-1:0]    csr_wr_data = '0;
   logic                        feed_valid   = 1'b0;
   logic [VALUE_BITS-1:0]       feed_element = '0;
   logic                        take_ready   = 1'b0;

   nxc_req_if #(.VALUE_BITS(VALUE_BITS)) req_chan ();
   nxc_rsp_if #(.VALUE_BITS(VALUE_BITS)) rsp_chan ();

   assign req_chan.valid   = feed_valid;
   assign req_chan.element = feed_element;
   assign rsp_chan.ready   = take_ready;

   next_combination_unit #(
      .MAX_K(MAX_K),
      .VALUE_BITS(VALUE_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   // Predictor state: its own copy of the registers and of the element store.
   logic [SET_SIZE_BITS-1:0]    model_set_size    = SET_SIZE_RESET;
   logic [CHOOSE_SIZE_BITS-1:0] model_choose_size = CHOOSE_SIZE_RESET;
   logic [VALUE_BITS-1:0]       model_elements [MAX_K];
   int unsigned                 model_loaded = 0;

   successor_type         successors [$];
   logic [VALUE_BITS-1:0] pending_elements [$];
   int unsigned           failures = 0;

   // Settings as the stimulus sees them, with k already clamped to 1..MAX_K.
   int unsigned stim_n = SET_SIZE_RESET;
   int unsigned stim_k = CHOOSE_SIZE_RESET;

   int unsigned extreme_n [EXTREME_COUNT] = '{255, 1, 255, 16, 5, 0, 200, 170, 1, 20};
   int unsigned extreme_k [EXTREME_COUNT] = '{16, 1, 1, 16, 16, 0, 31, 17, 2, 5};

   // First combination, last one, a mid one, out-of-range elements and a partial load.
   logic [VALUE_BITS-1:0] directed_elements [23] = '{
      8'd1, 8'd2, 8'd3,     8'd6, 8'd7, 8'd8,     8'd1, 8'd7, 8'd8,
      8'd3, 8'd5, 8'd8,     8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0,
      8'd8, 8'd8, 8'd8,     8'd4, 8'd5
   };

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   function automatic int unsigned draw_wait(input bit calm);
      if (calm) begin
         return 0;
      end
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // Takes one accepted element; once k are in, queues the successor combination or a no-next result.
   function automatic void advance_combination(input logic [VALUE_BITS-1:0] element);
      int                    k;
      int                    grow;
      int                    limit;
      int                    held;
      logic [VALUE_BITS-1:0] base;
      successor_type         result;
      k = (model_choose_size == 0) ? 1 :
          (model_choose_size > MAX_K) ? MAX_K : int'(model_choose_size);
      if (model_loaded >= k) begin
         model_loaded = 0;
      end
      model_elements[model_loaded] = element;
      model_loaded++;
      if (model_loaded < k) begin
         return;
      end
      model_loaded = 0;

      // Rightmost position whose value can still grow, tested in signed terms.
      grow = -1;
      for (int p = k - 1; p >= 0 && grow < 0; p--) begin
         limit = int'(model_set_size) - k + p + 1;
         held  = int'(model_elements[p]);
         if (held < limit) begin
            grow = p;
         end
      end

      if (grow < 0) begin
         result.element_res = '0;
         result.last        = 1'b1;
         result.no_next     = 1'b1;
         successors = {successors, result};
         return;
      end

      base = model_elements[grow] + 1'b1;
      for (int j = grow; j < k; j++) begin
         model_elements[j] = base + VALUE_BITS'(j - grow);
      end
      for (int j = 0; j < k; j++) begin
         result.element_res = model_elements[j];
         result.last        = (j == k - 1);
         result.no_next     = 1'b0;
         successors = {successors, result};
      end
   endfunction

   // Queues a well-formed combination; positions from tail on are set to their maximum.
   function automatic int unsigned queue_combination(input int unsigned tail);
      logic [VALUE_BITS-1:0] combo [MAX_K];
      int unsigned           need;
      int unsigned           idx;
      need = stim_k;
      idx  = 0;
      for (int unsigned v = 1; v <= stim_n && need != 0; v++) begin
         if ($urandom_range(0, stim_n - v) < need) begin
            combo[idx] = VALUE_BITS'(v);
            idx++;
            need--;
         end
      end
      for (int unsigned j = tail; j < stim_k; j++) begin
         combo[j] = VALUE_BITS'(stim_n - stim_k + 1 + j);
      end
      for (int unsigned j = 0; j < stim_k; j++) begin
         pending_elements = {pending_elements, combo[j]};
      end
      return stim_k;
   endfunction

   function automatic void queue_noise(input int unsigned count);
      repeat (count) begin
         pending_elements = {pending_elements, VALUE_BITS'($urandom_range(0, 255))};
      end
   endfunction

   task automatic write_register(input csr_index_type index,
                                 input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
   endtask

   // Writes set_size (which 0), choose_size (which 1) or both (any other value).
   task automatic apply_settings(input int unsigned n_value, input int unsigned k_value,
                                 input int unsigned which);
      logic [CSR_DATA_BITS-1:0] data;
      if (which != 1) begin
         write_register(CSR_SET_SIZE, CSR_DATA_BITS'(n_value));
         stim_n = n_value;
      end
      if (which != 0) begin
         // Upper data bits are random; the register keeps only its own width.
         data = CSR_DATA_BITS'($urandom);
         data[CHOOSE_SIZE_BITS-1:0] = CHOOSE_SIZE_BITS'(k_value);
         write_register(CSR_CHOOSE_SIZE, data);
         stim_k = (k_value == 0) ? 1 : (k_value > MAX_K) ? MAX_K : k_value;
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Waits until every element is sent and every result is back, then lets the block settle.
   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (pending_elements.size() != 0 || feed_valid || successors.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Element driver: each element waits a random number of cycles, except in calm stretches.
   int unsigned feed_hold = 0;
   bit          feed_calm = 1'b0;

   always @(posedge clock) begin : element_driver
      int unsigned gap;
      if (reset) begin
         feed_valid <= 1'b0;
      end else if (feed_valid && req_chan.ready) begin
         if ($urandom_range(0, 29) == 0) begin
            feed_calm = !feed_calm;
         end
         gap = draw_wait(feed_calm);
         if (gap == 0 && pending_elements.size() != 0) begin
            feed_element <= pending_elements.pop_front();
         end else begin
            feed_valid <= 1'b0;
            feed_hold = gap;
         end
      end else if (!feed_valid) begin
         if (feed_hold != 0) begin
            feed_hold--;
         end else if (pending_elements.size() != 0) begin
            feed_valid   <= 1'b1;
            feed_element <= pending_elements.pop_front();
         end
      end
   end

   // Result receiver: after each transfer it may stall for a random number of cycles.
   int unsigned take_hold = 0;
   bit          take_calm = 1'b0;

   always @(posedge clock) begin : result_receiver
      if (reset) begin
         take_ready <= 1'b0;
         take_hold = 0;
      end else if (take_ready) begin
         if (rsp_chan.valid) begin
            if ($urandom_range(0, 29) == 0) begin
               take_calm = !take_calm;
            end
            take_hold = draw_wait(take_calm);
            if (take_hold != 0) begin
               take_ready <= 1'b0;
            end
         end
      end else if (take_hold != 0) begin
         take_hold--;
      end else begin
         take_ready <= 1'b1;
      end
   end

   // Monitor: tracks register writes, predicts on each element transfer, checks each result.
   always @(posedge clock) begin : result_monitor
      successor_type seen;
      successor_type wanted;
      if (!reset) begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SET_SIZE: begin
                  model_set_size = csr_wr_data[SET_SIZE_BITS-1:0];
                  model_loaded   = 0;
               end
               CSR_CHOOSE_SIZE: begin
                  model_choose_size = csr_wr_data[CHOOSE_SIZE_BITS-1:0];
                  model_loaded      = 0;
               end
               default: begin
               end
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            advance_combination(req_chan.element);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.element_res = rsp_chan.element_res;
            seen.last        = rsp_chan.last;
            seen.no_next     = rsp_chan.no_next;
            if (successors.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT) begin
                  $display("unexpected result: element %0d last %0b no_next %0b",
                           seen.element_res, seen.last, seen.no_next);
               end
            end else begin
               wanted = successors.pop_front();
               if (seen !== wanted) begin
                  failures++;
                  if (failures <= REPORT_LIMIT) begin
                     $display("mismatch: expected element %0d last %0b no_next %0b, got %0d %0b %0b",
                              wanted.element_res, wanted.last, wanted.no_next,
                              seen.element_res, seen.last, seen.no_next);
                  end
               end
            end
         end
      end
   end

   // Stimulus: a directed phase at the reset settings, then random phases over many settings.
   initial begin : stimulus
      int unsigned sent;
      int unsigned budget;
      int unsigned phase;
      int unsigned n_value;
      int unsigned k_value;
      int unsigned which;
      int unsigned tail;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      foreach (directed_elements[i]) begin
         pending_elements = {pending_elements, directed_elements[i]};
      end
      wait_idle();

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase < EXTREME_COUNT) begin
            n_value = extreme_n[phase];
            k_value = extreme_k[phase];
            which   = 2;
         end else begin
            n_value = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 24);
            k_value = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
            which   = $urandom_range(0, 3);
         end
         apply_settings(n_value, k_value, which);

         @(negedge clock);
         budget = sent + $urandom_range(24, 48);
         while (sent < budget) begin
            if (stim_n >= stim_k && $urandom_range(0, 4) != 0) begin
               tail = ($urandom_range(0, 2) == 0) ? $urandom_range(0, stim_k) : stim_k;
               sent += queue_combination(tail);
            end else begin
               queue_noise(stim_k);
               sent += stim_k;
            end
         end
         // Sometimes leave a partial load behind for the next register write to drop.
         if (stim_k > 1 && $urandom_range(0, 2) == 0) begin
            n_value = $urandom_range(1, stim_k - 1);
            queue_noise(n_value);
            sent += n_value;
         end
         wait_idle();
         phase++;
      end

      if (failures == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

### next_combination_unit.f
rtl/nxc_pkg.sv
rtl/nxc_req_if.sv
rtl/nxc_rsp_if.sv
rtl/nxc_ram.sv
rtl/next_combination_unit.sv
tb/testbench.sv
